>>> rtl/sbhit_pkg.sv
// package for the segment versus rotated box hit test
// widths, word types, sine table and control struct; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sbhit_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int CEN_WIDTH   = COORD_WIDTH + 1;
   localparam int PT_WIDTH    = COORD_WIDTH + 2;
   localparam int DIFF_WIDTH  = PT_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 1;
   localparam int TEST_WIDTH  = SUM_WIDTH + 1;
   localparam int TRIG_WIDTH  = 16;
   localparam int HALF_WIDTH  = 7;
   localparam int ROT_WIDTH   = HALF_WIDTH + 1 + TRIG_WIDTH;
   localparam int ROUND_SHIFT = 6;
   localparam int ANGLE_STEPS = 360;
   localparam int QUARTER     = ANGLE_STEPS / 4;
   localparam int IDX_WIDTH   = 7;
   localparam int CFG_WIDTH   = 8;

   localparam logic [CFG_WIDTH-1:0] BOX_WIDTH_RESET  = 8'd60;
   localparam logic [CFG_WIDTH-1:0] BOX_HEIGHT_RESET = 8'd120;

   localparam logic CSR_BOX_WIDTH  = 1'b0;
   localparam logic CSR_BOX_HEIGHT = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [PT_WIDTH-1:0]    point_type;

   typedef struct packed {
      coord_type x1;
      coord_type y1;
      coord_type x2;
      coord_type y2;
   } seg_type;

   typedef struct packed {
      logic diff_en;
      logic prod_en;
      logic sum_en;
      logic test_en;
   } edge_ctl_type;

   // round(sin(d) * 2^14) for d = 0 .. 90 degrees
   localparam logic [14:0] SINE_Q14 [0:QUARTER] = '{
          0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
       2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
       5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
       8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
      10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
      12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
      14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
      15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
      16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
      16384
   };

endpackage

`default_nettype wire

>>> rtl/sbhit_edge.sv
// one box edge against the segment: differences, products, numerators, sign test
// four register stages; depends on sbhit_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbhit_edge
   import sbhit_pkg::*;
(
   input  wire logic         clock,
   input  wire edge_ctl_type ctl,
   input  wire seg_type      seg,
   input  wire point_type    p3x,
   input  wire point_type    p3y,
   input  wire point_type    p4x,
   input  wire point_type    p4y,
   output logic              hit
);

   logic signed [DIFF_WIDTH-1:0] d43x_ff, d43y_ff, d21x_ff, d21y_ff, d13x_ff, d13y_ff;
   logic signed [PROD_WIDTH-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [SUM_WIDTH-1:0]  den_ff, na_ff, nb_ff;
   logic signed [TEST_WIDTH-1:0] ra_in, rb_in;
   logic                         hit_in, hit_ff;
   logic                         ok_a, ok_b;

   always_ff @(posedge clock) begin
      if (ctl.diff_en) begin
         d43x_ff <= DIFF_WIDTH'(p4x) - DIFF_WIDTH'(p3x);
         d43y_ff <= DIFF_WIDTH'(p4y) - DIFF_WIDTH'(p3y);
         d21x_ff <= DIFF_WIDTH'(seg.x2) - DIFF_WIDTH'(seg.x1);
         d21y_ff <= DIFF_WIDTH'(seg.y2) - DIFF_WIDTH'(seg.y1);
         d13x_ff <= DIFF_WIDTH'(seg.x1) - DIFF_WIDTH'(p3x);
         d13y_ff <= DIFF_WIDTH'(seg.y1) - DIFF_WIDTH'(p3y);
      end
      if (ctl.prod_en) begin
         m0_ff <= d43y_ff * d21x_ff;
         m1_ff <= d43x_ff * d21y_ff;
         m2_ff <= d43x_ff * d13y_ff;
         m3_ff <= d43y_ff * d13x_ff;
         m4_ff <= d21x_ff * d13y_ff;
         m5_ff <= d21y_ff * d13x_ff;
      end
      if (ctl.sum_en) begin
         den_ff <= SUM_WIDTH'(m0_ff) - SUM_WIDTH'(m1_ff);
         na_ff  <= SUM_WIDTH'(m2_ff) - SUM_WIDTH'(m3_ff);
         nb_ff  <= SUM_WIDTH'(m4_ff) - SUM_WIDTH'(m5_ff);
      end
      if (ctl.test_en) begin
         hit_ff <= hit_in;
      end
   end

   always_comb begin
      ra_in = TEST_WIDTH'(den_ff) - TEST_WIDTH'(na_ff);
      rb_in = TEST_WIDTH'(den_ff) - TEST_WIDTH'(nb_ff);
      if (!den_ff[SUM_WIDTH-1]) begin
         ok_a = !na_ff[SUM_WIDTH-1] && !ra_in[TEST_WIDTH-1];
         ok_b = !nb_ff[SUM_WIDTH-1] && !rb_in[TEST_WIDTH-1];
      end else begin
         ok_a = (na_ff[SUM_WIDTH-1] || na_ff == '0) && (ra_in[TEST_WIDTH-1] || ra_in == '0);
         ok_b = (nb_ff[SUM_WIDTH-1] || nb_ff == '0) && (rb_in[TEST_WIDTH-1] || rb_in == '0);
      end
      hit_in = (den_ff != '0) && ok_a && ok_b;
   end

   assign hit = hit_ff;

endmodule

`default_nettype wire

>>> rtl/segment_rotated_box_hit_test.sv
// top level of the segment versus rotated box hit test
// angle decode, sine lookup, corner rotation, four sbhit_edge units; uses sbhit_pkg
//
//  port group   direction  handshake          contents
//  req_*        in         req_valid/ready    segment, box corner, angle
//  rsp_*        out        rsp_valid/ready    hit flag
//  csr_*        in         csr_write          box_width (0), box_height (1)
//
// one word per cycle unless a stalled output (rsp_ready low) has backed the pipeline up;
// a word passes through nine register stages, the first loaded at the accepting
// edge (angle, table, rotate, corner, edge difference, edge product, numerator,
// sign test, output)
// reset is synchronous, clears the valid bits and loads the box size registers with their reset values
// each stage moves when it is empty or the next one moves, so bubbles close up

`timescale 1ns / 1ps
`default_nettype none

module segment_rotated_box_hit_test
   import sbhit_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [COORD_WIDTH-1:0] req_seg_start_x,
   input  wire logic [COORD_WIDTH-1:0] req_seg_start_y,
   input  wire logic [COORD_WIDTH-1:0] req_seg_end_x,
   input  wire logic [COORD_WIDTH-1:0] req_seg_end_y,
   input  wire logic [COORD_WIDTH-1:0] req_box_left,
   input  wire logic [COORD_WIDTH-1:0] req_box_top,
   input  wire logic [8:0]             req_turn_degrees,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_hit,
   input  wire logic                   csr_write,
   input  wire logic                   csr_index,
   input  wire logic [CFG_WIDTH-1:0]   csr_data
);

   localparam int NSTAGE = 8;

   logic [CFG_WIDTH-1:0] width_ff, height_ff;
   logic [NSTAGE-1:0]    valid_ff;
   logic [NSTAGE-1:0]    en;
   logic                 out_en;
   logic                 rsp_valid_ff, rsp_hit_ff;

   // stage a
   logic [8:0]                  ang_in;
   logic [1:0]                  quad_in, cquad_in;
   logic [IDX_WIDTH-1:0]        rem_in;
   logic [IDX_WIDTH-1:0]        sidx_ff, cidx_ff;
   logic                        sneg_ff, cneg_ff;
   logic [HALF_WIDTH-1:0]       hw_a_ff, hh_a_ff;
   logic signed [CEN_WIDTH-1:0] cx_a_ff, cy_a_ff;
   seg_type                     seg_a_ff;

   // stage b
   logic signed [TRIG_WIDTH-1:0] sin_ff, cos_ff, smag_in, cmag_in;
   logic [HALF_WIDTH-1:0]        hw_b_ff, hh_b_ff;
   logic signed [CEN_WIDTH-1:0]  cx_b_ff, cy_b_ff;
   seg_type                      seg_b_ff;

   // stage c
   logic signed [ROT_WIDTH-1:0] hwc_ff, hhs_ff, hws_ff, hhc_ff;
   logic signed [CEN_WIDTH-1:0] cx_c_ff, cy_c_ff;
   seg_type                     seg_c_ff;

   // stage d
   point_type px_ff [4];
   point_type py_ff [4];
   point_type px_in [4];
   point_type py_in [4];
   seg_type   seg_d_ff;

   logic signed [ROT_WIDTH-1:0] rx, ry, rxr, ryr;
   localparam logic signed [ROT_WIDTH-1:0] ROUND_HALF = ROT_WIDTH'(32);

   edge_ctl_type edge_ctl;
   logic [3:0]   edge_hit;

   // stall chain
   always_comb begin
      out_en = !rsp_valid_ff || rsp_ready;
      en[NSTAGE-1] = !valid_ff[NSTAGE-1] || out_en;
      for (int i = NSTAGE - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= BOX_WIDTH_RESET;
         height_ff    <= BOX_HEIGHT_RESET;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_BOX_WIDTH: begin
                  width_ff <= csr_data;
               end
               CSR_BOX_HEIGHT: begin
                  height_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end
         if (en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NSTAGE; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
         if (out_en) begin
            rsp_valid_ff <= valid_ff[NSTAGE-1];
         end
      end
   end

   // angle decode
   always_comb begin
      ang_in = (req_turn_degrees >= 9'(ANGLE_STEPS)) ?
               req_turn_degrees - 9'(ANGLE_STEPS) : req_turn_degrees;
      if (ang_in < 9'(QUARTER)) begin
         quad_in = 2'd0;
         rem_in  = IDX_WIDTH'(ang_in);
      end else if (ang_in < 9'(2 * QUARTER)) begin
         quad_in = 2'd1;
         rem_in  = IDX_WIDTH'(ang_in - 9'(QUARTER));
      end else if (ang_in < 9'(3 * QUARTER)) begin
         quad_in = 2'd2;
         rem_in  = IDX_WIDTH'(ang_in - 9'(2 * QUARTER));
      end else begin
         quad_in = 2'd3;
         rem_in  = IDX_WIDTH'(ang_in - 9'(3 * QUARTER));
      end
      cquad_in = quad_in + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sidx_ff  <= quad_in[0] ? IDX_WIDTH'(QUARTER) - rem_in : rem_in;
         sneg_ff  <= quad_in[1];
         cidx_ff  <= cquad_in[0] ? IDX_WIDTH'(QUARTER) - rem_in : rem_in;
         cneg_ff  <= cquad_in[1];
         hw_a_ff  <= width_ff[CFG_WIDTH-1:1];
         hh_a_ff  <= height_ff[CFG_WIDTH-1:1];
         cx_a_ff  <= CEN_WIDTH'(signed'(req_box_left))
                   + CEN_WIDTH'(signed'({1'b0, width_ff, 7'b0}));
         cy_a_ff  <= CEN_WIDTH'(signed'(req_box_top))
                   + CEN_WIDTH'(signed'({1'b0, height_ff, 7'b0}));
         seg_a_ff <= '{x1: req_seg_start_x, y1: req_seg_start_y,
                       x2: req_seg_end_x,   y2: req_seg_end_y};
      end
   end

   // sine and cosine lookup
   assign smag_in = signed'({1'b0, SINE_Q14[sidx_ff]});
   assign cmag_in = signed'({1'b0, SINE_Q14[cidx_ff]});

   always_ff @(posedge clock) begin
      if (en[1]) begin
         sin_ff   <= sneg_ff ? -smag_in : smag_in;
         cos_ff   <= cneg_ff ? -cmag_in : cmag_in;
         hw_b_ff  <= hw_a_ff;
         hh_b_ff  <= hh_a_ff;
         cx_b_ff  <= cx_a_ff;
         cy_b_ff  <= cy_a_ff;
         seg_b_ff <= seg_a_ff;
      end
   end

   // rotation products
   always_ff @(posedge clock) begin
      if (en[2]) begin
         hwc_ff   <= signed'({1'b0, hw_b_ff}) * cos_ff;
         hhs_ff   <= signed'({1'b0, hh_b_ff}) * sin_ff;
         hws_ff   <= signed'({1'b0, hw_b_ff}) * sin_ff;
         hhc_ff   <= signed'({1'b0, hh_b_ff}) * cos_ff;
         cx_c_ff  <= cx_b_ff;
         cy_c_ff  <= cy_b_ff;
         seg_c_ff <= seg_b_ff;
      end
   end

   // corners: bit 1 picks +hw, bit 0 picks +hh
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rx = (k[1] ? hwc_ff : -hwc_ff) - (k[0] ? hhs_ff : -hhs_ff);
         ry = (k[1] ? hws_ff : -hws_ff) + (k[0] ? hhc_ff : -hhc_ff);
         rxr = (rx + ROUND_HALF) >>> ROUND_SHIFT;
         ryr = (ry + ROUND_HALF) >>> ROUND_SHIFT;
         px_in[k] = PT_WIDTH'(cx_c_ff) + PT_WIDTH'(rxr);
         py_in[k] = PT_WIDTH'(cy_c_ff) + PT_WIDTH'(ryr);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int k = 0; k < 4; k++) begin
            px_ff[k] <= px_in[k];
            py_ff[k] <= py_in[k];
         end
         seg_d_ff <= seg_c_ff;
      end
   end

   assign edge_ctl = '{diff_en: en[4], prod_en: en[5], sum_en: en[6], test_en: en[7]};

   sbhit_edge u_edge_left (
      .clock (clock), .ctl (edge_ctl), .seg (seg_d_ff),
      .p3x (px_ff[0]), .p3y (py_ff[0]), .p4x (px_ff[1]), .p4y (py_ff[1]),
      .hit (edge_hit[0])
   );

   sbhit_edge u_edge_right (
      .clock (clock), .ctl (edge_ctl), .seg (seg_d_ff),
      .p3x (px_ff[2]), .p3y (py_ff[2]), .p4x (px_ff[3]), .p4y (py_ff[3]),
      .hit (edge_hit[1])
   );

   sbhit_edge u_edge_top (
      .clock (clock), .ctl (edge_ctl), .seg (seg_d_ff),
      .p3x (px_ff[0]), .p3y (py_ff[0]), .p4x (px_ff[2]), .p4y (py_ff[2]),
      .hit (edge_hit[2])
   );

   sbhit_edge u_edge_bottom (
      .clock (clock), .ctl (edge_ctl), .seg (seg_d_ff),
      .p3x (px_ff[1]), .p3y (py_ff[1]), .p4x (px_ff[3]), .p4y (py_ff[3]),
      .hit (edge_hit[3])
   );

   // output word
   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_hit_ff <= |edge_hit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with no word waiting at the output");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && $countones(valid_ff) == NSTAGE) |-> !req_ready)
      else $error("word accepted into a full, stalled pipeline");

   a_held_output: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(valid_ff[NSTAGE-1]) || !$past(valid_ff[NSTAGE-1]))
      else $error("last stage word lost during output stall");

   a_cfg_reset: assert property (@(posedge clock)
      $past(reset) |-> (width_ff == BOX_WIDTH_RESET && height_ff == BOX_HEIGHT_RESET))
      else $error("box size registers not at reset value");

endmodule

`default_nettype wire

>>> dv/segment_rotated_box_hit_test_tb.sv
// self-checking testbench for segment_rotated_box_hit_test: directed and random words
// through valid/ready, with random idling and box size changes; uses sbhit_pkg
`timescale 1ns / 1ps

module segment_rotated_box_hit_test_tb;
   import sbhit_pkg::*;

   class hit_board;
      bit pending[$];

      function void note(bit h);
         pending.push_back(h);
      endfunction

      // returns 1 when the word matches; orphan set when nothing is waiting
      function bit check(bit got, output bit want, output bit orphan);
         orphan = (pending.size() == 0);
         want = 1'b0;
         if (orphan) return 1'b0;
         want = pending.pop_front();
         return got == want;
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [COORD_WIDTH-1:0] req_seg_start_x;
   logic [COORD_WIDTH-1:0] req_seg_start_y;
   logic [COORD_WIDTH-1:0] req_seg_end_x;
   logic [COORD_WIDTH-1:0] req_seg_end_y;
   logic [COORD_WIDTH-1:0] req_box_left;
   logic [COORD_WIDTH-1:0] req_box_top;
   logic [8:0]             req_turn_degrees;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_hit;
   logic                   csr_write;
   logic                   csr_index;
   logic [CFG_WIDTH-1:0]   csr_data;

   hit_board           board;
   int                 fails;
   int                 send_idle_pct;
   int                 stall_pct;
   logic [CFG_WIDTH-1:0] box_w;
   logic [CFG_WIDTH-1:0] box_h;

   segment_rotated_box_hit_test dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_seg_start_x(req_seg_start_x), .req_seg_start_y(req_seg_start_y),
      .req_seg_end_x(req_seg_end_x), .req_seg_end_y(req_seg_end_y),
      .req_box_left(req_box_left), .req_box_top(req_box_top),
      .req_turn_degrees(req_turn_degrees),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic longint sine_of(int a);
      int q;
      int r;
      longint m;
      q = (a / QUARTER) % 4;
      r = a % QUARTER;
      m = (q % 2 == 1) ? longint'(SINE_Q14[QUARTER - r]) : longint'(SINE_Q14[r]);
      return (q >= 2) ? -m : m;
   endfunction

   function automatic bit within_unit(longint num, longint den);
      if (den > 0) return num >= 0 && den - num >= 0;
      return num <= 0 && den - num <= 0;
   endfunction

   function automatic bit edge_crossed(longint x1, longint y1, longint x2, longint y2,
                                       longint x3, longint y3, longint x4, longint y4);
      longint den;
      longint na;
      longint nb;
      den = (y4 - y3) * (x2 - x1) - (x4 - x3) * (y2 - y1);
      na  = (x4 - x3) * (y1 - y3) - (y4 - y3) * (x1 - x3);
      nb  = (x2 - x1) * (y1 - y3) - (y2 - y1) * (x1 - x3);
      if (den == 0) return 1'b0;
      return within_unit(na, den) && within_unit(nb, den);
   endfunction

   function automatic bit box_hit(logic [COORD_WIDTH-1:0] sx, logic [COORD_WIDTH-1:0] sy,
                                  logic [COORD_WIDTH-1:0] ex, logic [COORD_WIDTH-1:0] ey,
                                  logic [COORD_WIDTH-1:0] bl, logic [COORD_WIDTH-1:0] bt,
                                  logic [8:0] turn);
      longint px[4];
      longint py[4];
      longint s;
      longint c;
      longint hw;
      longint hh;
      longint cx;
      longint cy;
      longint ox;
      longint oy;
      int ang;
      ang = turn;
      if (ang >= ANGLE_STEPS) ang -= ANGLE_STEPS;
      s = sine_of(ang);
      c = sine_of((ang + QUARTER) % ANGLE_STEPS);
      hw = box_w >> 1;
      hh = box_h >> 1;
      cx = longint'(coord_type'(bl)) + longint'(box_w) * 128;
      cy = longint'(coord_type'(bt)) + longint'(box_h) * 128;
      for (int k = 0; k < 4; k++) begin
         ox = (k >= 2) ? hw : -hw;
         oy = (k % 2 == 1) ? hh : -hh;
         px[k] = cx + ((ox * c - oy * s + 32) >>> ROUND_SHIFT);
         py[k] = cy + ((ox * s + oy * c + 32) >>> ROUND_SHIFT);
      end
      return edge_crossed(coord_type'(sx), coord_type'(sy), coord_type'(ex), coord_type'(ey),
                          px[0], py[0], px[1], py[1])
          || edge_crossed(coord_type'(sx), coord_type'(sy), coord_type'(ex), coord_type'(ey),
                          px[2], py[2], px[3], py[3])
          || edge_crossed(coord_type'(sx), coord_type'(sy), coord_type'(ex), coord_type'(ey),
                          px[0], py[0], px[2], py[2])
          || edge_crossed(coord_type'(sx), coord_type'(sy), coord_type'(ex), coord_type'(ey),
                          px[1], py[1], px[3], py[3]);
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fails++;
   endtask

   task automatic send_word(int sx, int sy, int ex, int ey, int bl, int bt, int turn);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_seg_start_x  <= sx[COORD_WIDTH-1:0];
      req_seg_start_y  <= sy[COORD_WIDTH-1:0];
      req_seg_end_x    <= ex[COORD_WIDTH-1:0];
      req_seg_end_y    <= ey[COORD_WIDTH-1:0];
      req_box_left     <= bl[COORD_WIDTH-1:0];
      req_box_top      <= bt[COORD_WIDTH-1:0];
      req_turn_degrees <= turn[8:0];
      req_valid        <= 1'b1;
      do @(posedge clock); while (!req_ready);
      board.note(box_hit(req_seg_start_x, req_seg_start_y, req_seg_end_x, req_seg_end_y,
                         req_box_left, req_box_top, req_turn_degrees));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_box(logic [CFG_WIDTH-1:0] w, logic [CFG_WIDTH-1:0] h);
      csr_write <= 1'b1;
      csr_index <= CSR_BOX_WIDTH;
      csr_data  <= w;
      @(negedge clock);
      csr_index <= CSR_BOX_HEIGHT;
      csr_data  <= h;
      @(negedge clock);
      csr_write <= 1'b0;
      box_w = w;
      box_h = h;
      @(negedge clock);
   endtask

   task automatic send_random();
      int base_x;
      int base_y;
      int turn;
      turn = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(359);
      if ($urandom_range(9) < 7) begin
         base_x = $urandom_range(2097152) - 1048576;
         base_y = $urandom_range(2097152) - 1048576;
         send_word(base_x + $urandom_range(80000) - 40000, base_y + $urandom_range(80000) - 40000,
                   base_x + $urandom_range(80000) - 40000, base_y + $urandom_range(80000) - 40000,
                   base_x - $urandom_range(40000), base_y - $urandom_range(40000), turn);
      end else begin
         send_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, turn);
      end
   endtask

   always @(negedge clock) begin
      if (!reset) rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      bit want;
      bit orphan;
      if (!reset && rsp_valid && rsp_ready) begin
         if (!board.check(rsp_hit, want, orphan)) begin
            if (orphan) report_mismatch("hit word with nothing expected");
            else report_mismatch($sformatf("hit %0b, expected %0b", rsp_hit, want));
         end
      end
   end

   initial begin
      int idle_set[4];
      int stall_set[4];
      int wait_cycles;
      board = new();
      fails = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      box_w = BOX_WIDTH_RESET;
      box_h = BOX_HEIGHT_RESET;
      reset = 1'b1;
      req_valid = 1'b0;
      req_seg_start_x = '0;
      req_seg_start_y = '0;
      req_seg_end_x = '0;
      req_seg_end_y = '0;
      req_box_left = '0;
      req_box_top = '0;
      req_turn_degrees = '0;
      rsp_ready = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_BOX_WIDTH;
      csr_data = '0;
      idle_set = '{0, 69, 0, 22};
      stall_set = '{0, 0, 69, 22};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words at the reset box size (60 x 120), box corner at origin but for the extreme-coordinate words
      send_word(-1000, 15360, 30000, 15360, 0, 0, 0);
      send_word(7680, -5000, 7680, 40000, 0, 0, 90);
      send_word(0, 0, 0, 30720, 0, 0, 0);
      send_word(0, -100, 0, 0, 0, 0, 0);
      send_word(-5000, 0, 20000, 0, 0, 0, 0);
      send_word(100, 100, 200, 200, 0, 0, 0);
      send_word(7680, 15360, 9000, 16000, 0, 0, 45);
      send_word(-30000, 15360, 40000, 15360, 0, 0, 180);
      send_word(-30000, 15360, 40000, 15360, 0, 0, 270);
      send_word(7680, -30000, 7680, 50000, 0, 0, 359);
      send_word(7680, -30000, 7680, 50000, 0, 0, 360);
      send_word(7680, -30000, 7680, 50000, 0, 0, 511);
      send_word(-8388608, -8388608, 8388607, 8388607, 0, 0, 30);
      send_word(8388607, -8388608, -8388608, 8388607, 8388607, 8388607, 135);
      send_word(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608, 0);
      send_word(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 300);
      send_word(-8388608, 8388607, 8388607, -8388608, -8388608, 8388607, 225);
      send_word(100000, 100000, 200000, 300000, 0, 0, 10);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: write_box(8'd255, 8'd255);
            1: write_box(8'd0, 8'd1);
            2: write_box(8'd7, 8'd200);
            default: write_box(8'($urandom_range(255)), 8'($urandom_range(255)));
         endcase
         send_idle_pct = idle_set[ph];
         stall_pct = stall_set[ph];
         for (int n = 0; n < 500; n++) begin
            if (ph == 3 && n % 100 == 99) begin
               drain();
               write_box(8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            if (ph == 2 && n == 250) drain();
            send_random();
         end
         req_valid <= 1'b0;
         drain();
      end

      wait_cycles = 0;
      while (board.pending.size() != 0 && wait_cycles < 10000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (board.pending.size() != 0) report_mismatch("expected hit words never arrived");
      if (fails == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
